@@ rtl/smpg_pkg.sv @@
// ----------------------------------------------------------------------------
// smpg_pkg: shared types and constants of the S-curve profile generator
// Holds field widths, command and phase codes, settle thresholds and the
// operand bundle of the serial multiply-divide unit.
// ----------------------------------------------------------------------------
package smpg_pkg;

   localparam int unsigned MdW      = 48;   // operand and quotient width of the unit
   localparam int unsigned RspDataW = 104;  // 100 payload bits padded to whole bytes

   localparam logic [MdW-1:0] SatCap = {MdW{1'b1}};

   // Settle and snap thresholds in Q16.16.
   localparam logic [31:0] PosEps     = 32'd1;
   localparam logic [31:0] VelEps     = 32'd7;
   localparam logic [31:0] SettleDist = 32'd66;
   localparam logic [31:0] SettleVel  = 32'd6554;

   typedef enum logic [2:0] {
      ACT_TICK   = 3'd0,
      ACT_START  = 3'd1,
      ACT_PAUSE  = 3'd2,
      ACT_RESUME = 3'd3,
      ACT_ABORT  = 3'd4,
      ACT_CLEAR  = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_RUN   = 3'd1,
      PH_PAUSE = 3'd2,
      PH_DONE  = 3'd3,
      PH_ABORT = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      CSR_MAX_VEL  = 2'd0,
      CSR_MAX_ACC  = 2'd1,
      CSR_MAX_JERK = 2'd2,
      CSR_TICK     = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV
   } md_state_type;

   typedef enum logic [4:0] {
      CS_WAIT, CS_DECODE, CS_VE, CS_RAMP, CS_D1, CS_D2, CS_D3, CS_LATCH,
      CS_DA, CS_ADEC, CS_ACC, CS_MAG, CS_VEL, CS_DIST, CS_FIN, CS_PUT
   } ctl_state_type;

   // Operands of one floor(x*y/z) request.
   typedef struct packed {
      logic           start;
      logic [MdW-1:0] x;
      logic [MdW-1:0] y;
      logic [MdW-1:0] z;
   } md_req_type;

   typedef struct packed {
      logic           done;
      logic [MdW-1:0] q;
   } md_res_type;

   // Saturating add of two non-negative values at the intermediate cap.
   function automatic logic [MdW-1:0] sat_add(input logic [MdW-1:0] a,
                                              input logic [MdW-1:0] b);
      logic [MdW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[MdW] ? SatCap : s[MdW-1:0];
   endfunction

endpackage

@@ rtl/scurve_motion_profile_generator.sv @@
// ----------------------------------------------------------------------------
// scurve_motion_profile_generator: one-axis jerk-limited path profile
// Command-driven S-curve (or trapezoid) generator with a serial arithmetic
// core; one result beat for every command beat.
// ----------------------------------------------------------------------------
// Usage:
// Each beat on the req_ channel carries one command in req_tuser (tick, start,
// pause, resume, abort, clear) and, for start, the signed Q16.16 path length
// in req_tdata. Every command yields exactly one beat on the rsp_ channel with
// position, velocity, acceleration, phase and the accepted flag.
// The csr_ channel writes the velocity, acceleration and jerk caps and the
// tick period; it is always ready and must only be used while idle.
// For non-tick commands and ticks that do nothing, the command passes from
// the decode state to the put state, which registers the result beat once the
// output register is free; the next command is accepted back in the wait state.
// A moving tick runs a chain of up to nine floor(x*y/z) operations through
// the single bit-serial multiply-divide unit. Each operation is a
// shift-and-add multiply over the significant multiplier bits followed by a
// restoring division. That unit sets the throughput: one command is in work
// at a time.
// The result sits in an output register; a new command is accepted while it
// waits, and work stalls only when the next result is ready and the receiver
// has not yet taken the previous one.
// Reset clears the motion state to idle, the caps to zero and the tick
// period to its default of about one millisecond.
// ----------------------------------------------------------------------------
module scurve_motion_profile_generator
   import smpg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // Command channel.
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [31:0]         req_tdata,   // [31:0] start_length
   input  logic [2:0]          req_tuser,   // [2:0] action
   // Result channel.
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,   // [31:0] position, [63:32] velocity,
                                            // [95:64] acceleration, [98:96] phase,
                                            // [99] accepted, [103:100] zero
   // Register writes.
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data
);

   // Configuration registers.
   logic [31:0] maxv_ff;
   logic [30:0] maxa_ff;
   logic [30:0] maxj_ff;
   logic [31:0] tper_ff;

   // Motion state.
   phase_type          phase_ff, phase_in;
   logic [31:0]        total_ff, total_in;
   logic signed [33:0] rem_ff, rem_in;
   logic [31:0]        vel_ff, vel_in;
   logic signed [31:0] acc_ff, acc_in;
   logic               latch_ff, latch_in;

   // Command being worked on and per-tick temporaries.
   ctl_state_type      state_ff, state_in;
   action_type         act_ff;
   logic [31:0]        len_ff;
   logic               ok_ff, ok_in;
   logic [MdW-1:0]     ve_ff, ve_in;
   logic [MdW-1:0]     dsum_ff, dsum_in;
   logic [31:0]        vt_ff, vt_in;
   logic [30:0]        da_ff, da_in;
   logic [MdW-1:0]     adec_ff, adec_in;
   logic [MdW-1:0]     mag_ff, mag_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0] rsp_data_ff, rsp_data_in;

   // Multiply-divide unit handshake.
   md_req_type md_req;
   md_res_type md_res;
   logic       launched_ff, launched_in;
   logic       op_state;

   logic       jerk_on;
   logic [31:0] acc_mag;
   logic        req_fire;
   logic        put_ok;

   assign jerk_on  = (maxj_ff != '0);
   assign acc_mag  = acc_ff[31] ? (32'd0 - acc_ff) : acc_ff;
   assign req_fire = req_tvalid && req_tready;
   assign put_ok   = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == CS_WAIT);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   smpg_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .req   (md_req),
      .res   (md_res)
   );

   // Operand selection for the shared unit.
   always_comb begin
      op_state = 1'b1;
      md_req.x = '0;
      md_req.y = '0;
      md_req.z = '0;
      case (state_ff)
         CS_VE: begin
            md_req.x = {17'd0, acc_ff[30:0]};
            md_req.y = {10'd0, acc_ff[30:0], 7'd0};
            md_req.z = {17'd0, maxj_ff};
         end
         CS_RAMP: begin
            md_req.x = ve_ff;
            md_req.y = {17'd0, acc_ff[30:0]};
            md_req.z = {17'd0, maxj_ff};
         end
         CS_D1: begin
            md_req.x = ve_ff;
            md_req.y = ve_ff;
            md_req.z = {8'd0, maxa_ff, 9'd0};
         end
         CS_D2: begin
            md_req.x = ve_ff;
            md_req.y = {16'd0, tper_ff};
            md_req.z = MdW'(1) << 33;
         end
         CS_D3: begin
            md_req.x = ve_ff;
            md_req.y = {17'd0, maxa_ff};
            md_req.z = {16'd0, maxj_ff, 1'b0};
         end
         CS_DA: begin
            md_req.x = {17'd0, maxj_ff};
            md_req.y = {16'd0, tper_ff};
            md_req.z = MdW'(1) << 32;
         end
         CS_ADEC: begin
            md_req.x = {16'd0, acc_mag};
            md_req.y = {9'd0, acc_mag, 7'd0};
            md_req.z = {17'd0, maxj_ff};
         end
         CS_MAG: begin
            md_req.x = {16'd0, acc_mag};
            md_req.y = {16'd0, tper_ff};
            md_req.z = MdW'(1) << 24;
         end
         CS_DIST: begin
            md_req.x = {16'd0, vel_ff};
            md_req.y = {16'd0, tper_ff};
            md_req.z = MdW'(1) << 32;
         end
         default: begin
            op_state = 1'b0;
         end
      endcase
      md_req.start = op_state && !launched_ff;
   end

   assign launched_in = (launched_ff || md_req.start) && !md_res.done;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_WAIT: begin
            if (req_fire) begin
               state_in = CS_DECODE;
            end
         end
         CS_DECODE: begin
            state_in = CS_PUT;
            if (act_ff == ACT_TICK && tper_ff != '0) begin
               if (phase_ff == PH_RUN) begin
                  if (vel_ff == '0) begin
                     state_in = CS_LATCH;
                  end else if (jerk_on && !acc_ff[31] && acc_ff != '0) begin
                     state_in = CS_VE;
                  end else begin
                     state_in = CS_D1;
                  end
               end else if (phase_ff == PH_PAUSE || phase_ff == PH_ABORT) begin
                  state_in = jerk_on ? CS_DA : CS_ACC;
               end
            end
         end
         CS_VE:    if (md_res.done) state_in = CS_RAMP;
         CS_RAMP:  if (md_res.done) state_in = CS_D1;
         CS_D1:    if (md_res.done) state_in = CS_D2;
         CS_D2:    if (md_res.done) state_in = jerk_on ? CS_D3 : CS_LATCH;
         CS_D3:    if (md_res.done) state_in = CS_LATCH;
         CS_LATCH: state_in = jerk_on ? CS_DA : CS_ACC;
         CS_DA:    if (md_res.done) state_in = CS_ADEC;
         CS_ADEC:  if (md_res.done) state_in = CS_ACC;
         CS_ACC:   state_in = CS_MAG;
         CS_MAG:   if (md_res.done) state_in = CS_VEL;
         CS_VEL:   state_in = CS_DIST;
         CS_DIST:  if (md_res.done) state_in = CS_FIN;
         CS_FIN:   state_in = CS_PUT;
         CS_PUT: begin
            if (put_ok) begin
               state_in = CS_WAIT;
            end
         end
         default: begin
            state_in = CS_WAIT;
         end
      endcase
   end

   // Datapath updates per state.
   always_comb begin
      logic               latch_now;
      logic signed [50:0] adec_s;
      logic signed [50:0] sw;
      logic signed [33:0] ades;
      logic signed [33:0] step;
      logic signed [33:0] da_s;
      logic signed [33:0] acc_new;
      logic signed [41:0] nv;
      logic signed [34:0] pos;

      phase_in     = phase_ff;
      total_in     = total_ff;
      rem_in       = rem_ff;
      vel_in       = vel_ff;
      acc_in       = acc_ff;
      latch_in     = latch_ff;
      ok_in        = ok_ff;
      ve_in        = ve_ff;
      dsum_in      = dsum_ff;
      vt_in        = vt_ff;
      da_in        = da_ff;
      adec_in      = adec_ff;
      mag_in       = mag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      latch_now = latch_ff || (!rem_ff[33] && ({15'd0, rem_ff[32:0]} <= dsum_ff));
      adec_s    = acc_ff[31] ? -$signed({3'd0, adec_ff}) : $signed({3'd0, adec_ff});
      sw        = $signed({19'd0, vt_ff}) - $signed({19'd0, vel_ff}) - adec_s;
      da_s      = $signed({3'd0, da_ff});
      ades      = '0;
      if (sw > 0) begin
         ades = $signed({3'd0, maxa_ff});
      end else if (sw < 0) begin
         ades = -$signed({3'd0, maxa_ff});
      end
      step = ades - 34'(acc_ff);
      if (step > da_s) begin
         step = da_s;
      end
      if (step < -da_s) begin
         step = -da_s;
      end
      acc_new = 34'(acc_ff) + step;

      nv = acc_ff[31] ? ($signed({10'd0, vel_ff}) - $signed({2'd0, mag_ff[39:0]}))
                      : ($signed({10'd0, vel_ff}) + $signed({2'd0, mag_ff[39:0]}));
      if (!jerk_on) begin
         if (!acc_ff[31] && acc_ff != '0 && nv > $signed({10'd0, vt_ff})) begin
            nv = $signed({10'd0, vt_ff});
         end
         if (acc_ff[31] && nv < $signed({10'd0, vt_ff})) begin
            nv = $signed({10'd0, vt_ff});
         end
      end
      if (nv < 0) begin
         nv = '0;
      end
      if (nv > $signed({10'd0, maxv_ff})) begin
         nv = $signed({10'd0, maxv_ff});
      end

      pos = $signed({3'd0, total_ff}) - 35'(rem_ff);
      if (pos < 0) begin
         pos = '0;
      end

      case (state_ff)
         CS_DECODE: begin
            ok_in = 1'b1;
            case (act_ff)
               ACT_TICK: begin
                  if (tper_ff != '0 && phase_ff == PH_RUN) begin
                     // Release the latch to creep on after stopping short.
                     if (latch_ff && vel_ff <= VelEps && rem_ff > $signed({2'd0, SettleDist})) begin
                        latch_in = 1'b0;
                     end
                     ve_in   = {16'd0, vel_ff};
                     dsum_in = '0;
                  end
                  vt_in = '0;
               end
               ACT_START: begin
                  phase_in = PH_IDLE;
                  total_in = '0;
                  rem_in   = '0;
                  vel_in   = '0;
                  acc_in   = '0;
                  latch_in = 1'b0;
                  if (maxv_ff == '0 || maxa_ff == '0) begin
                     ok_in = 1'b0;
                  end else if (len_ff[31]) begin
                     phase_in = PH_DONE;
                     ok_in    = 1'b0;
                  end else begin
                     total_in = len_ff;
                     if (len_ff <= PosEps) begin
                        phase_in = PH_DONE;
                     end else begin
                        rem_in   = $signed({2'd0, len_ff});
                        phase_in = PH_RUN;
                     end
                  end
               end
               ACT_PAUSE: begin
                  if (phase_ff == PH_RUN) begin
                     phase_in = PH_PAUSE;
                  end
               end
               ACT_RESUME: begin
                  if (phase_ff == PH_PAUSE) begin
                     phase_in = PH_RUN;
                     latch_in = 1'b0;
                  end
               end
               ACT_ABORT: begin
                  if (phase_ff == PH_RUN || phase_ff == PH_PAUSE) begin
                     phase_in = PH_ABORT;
                  end
               end
               ACT_CLEAR: begin
                  phase_in = PH_IDLE;
                  total_in = '0;
                  rem_in   = '0;
                  vel_in   = '0;
                  acc_in   = '0;
                  latch_in = 1'b0;
               end
               default: begin
               end
            endcase
         end
         CS_VE: begin
            if (md_res.done) begin
               ve_in = sat_add({16'd0, vel_ff}, md_res.q);
            end
         end
         CS_RAMP: begin
            if (md_res.done) begin
               dsum_in = md_res.q;
            end
         end
         CS_D1, CS_D2, CS_D3: begin
            if (md_res.done) begin
               dsum_in = sat_add(dsum_ff, md_res.q);
            end
         end
         CS_LATCH: begin
            latch_in = latch_now;
            vt_in    = latch_now ? 32'd0 : maxv_ff;
         end
         CS_DA: begin
            if (md_res.done) begin
               da_in = md_res.q[30:0];
            end
         end
         CS_ADEC: begin
            if (md_res.done) begin
               adec_in = md_res.q;
            end
         end
         CS_ACC: begin
            if (jerk_on) begin
               acc_in = acc_new[31:0];
            end else if (vel_ff < vt_ff) begin
               acc_in = $signed({1'b0, maxa_ff});
            end else if (vel_ff > vt_ff) begin
               acc_in = -$signed({1'b0, maxa_ff});
            end else begin
               acc_in = '0;
            end
         end
         CS_MAG: begin
            if (md_res.done) begin
               mag_in = md_res.q;
            end
         end
         CS_VEL: begin
            vel_in = nv[31:0];
         end
         CS_DIST: begin
            if (md_res.done) begin
               rem_in = rem_ff - $signed({2'd0, md_res.q[31:0]});
            end
         end
         CS_FIN: begin
            if (phase_ff == PH_ABORT) begin
               if (vel_ff <= VelEps) begin
                  vel_in = '0;
                  acc_in = '0;
               end
               if (rem_ff < 0) begin
                  rem_in = '0;
               end
            end else if (rem_ff <= $signed({2'd0, PosEps}) ||
                         (rem_ff <= $signed({2'd0, SettleDist}) && vel_ff <= SettleVel)) begin
               rem_in   = '0;
               vel_in   = '0;
               acc_in   = '0;
               phase_in = PH_DONE;
            end
         end
         CS_PUT: begin
            if (put_ok) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, ok_ff, phase_ff, acc_ff, vel_ff, pos[31:0]};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         maxv_ff      <= '0;
         maxa_ff      <= '0;
         maxj_ff      <= '0;
         tper_ff      <= 32'd4294967;
         phase_ff     <= PH_IDLE;
         total_ff     <= '0;
         rem_ff       <= '0;
         vel_ff       <= '0;
         acc_ff       <= '0;
         latch_ff     <= 1'b0;
         state_ff     <= CS_WAIT;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_MAX_VEL:  maxv_ff <= csr_data;
               CSR_MAX_ACC:  maxa_ff <= csr_data[30:0];
               CSR_MAX_JERK: maxj_ff <= csr_data[30:0];
               CSR_TICK:     tper_ff <= csr_data;
               default: begin
               end
            endcase
         end
         phase_ff     <= phase_in;
         total_ff     <= total_in;
         rem_ff       <= rem_in;
         vel_ff       <= vel_in;
         acc_ff       <= acc_in;
         latch_ff     <= latch_in;
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         act_ff <= action_type'(req_tuser);
         len_ff <= req_tdata;
      end
      ok_ff       <= ok_in;
      ve_ff       <= ve_in;
      dsum_ff     <= dsum_in;
      vt_ff       <= vt_in;
      da_ff       <= da_in;
      adec_ff     <= adec_in;
      mag_ff      <= mag_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ rtl/smpg_muldiv.sv @@
// ----------------------------------------------------------------------------
// smpg_muldiv: bit-serial floor(x*y/z) with saturation
// Shift-and-add multiply, one multiplier bit per cycle, then restoring
// division, one quotient bit per cycle. The result saturates at 2^48-1.
// ----------------------------------------------------------------------------
module smpg_muldiv
   import smpg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  md_req_type req,
   output md_res_type res
);

   localparam int unsigned CntW = $clog2(MdW);

   md_state_type       state_ff, state_in;
   logic [2*MdW-1:0]   acc_ff, acc_in;
   logic [2*MdW-1:0]   xs_ff, xs_in;
   logic [MdW-1:0]     ys_ff, ys_in;
   logic [MdW-1:0]     z_ff, z_in;
   logic [MdW-1:0]     rem_ff, rem_in;
   logic [MdW-1:0]     q_ff, q_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic               done_ff, done_in;

   logic [MdW:0]       r2;
   logic               ge;

   always_comb begin
      r2 = {rem_ff, ys_ff[MdW-1]};
      ge = (r2 >= {1'b0, z_ff});
   end

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      xs_in    = xs_ff;
      ys_in    = ys_ff;
      z_in     = z_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      case (state_ff)
         MD_IDLE: begin
            if (req.start) begin
               acc_in   = '0;
               xs_in    = {{MdW{1'b0}}, req.x};
               ys_in    = req.y;
               z_in     = req.z;
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            if (ys_ff == '0) begin
               // Product complete: a high half at or above z means q >= 2^48.
               if (z_ff == '0 || acc_ff[2*MdW-1:MdW] >= z_ff) begin
                  q_in     = SatCap;
                  done_in  = 1'b1;
                  state_in = MD_IDLE;
               end else begin
                  rem_in   = acc_ff[2*MdW-1:MdW];
                  ys_in    = acc_ff[MdW-1:0];
                  q_in     = '0;
                  cnt_in   = '0;
                  state_in = MD_DIV;
               end
            end else begin
               if (ys_ff[0]) begin
                  acc_in = acc_ff + xs_ff;
               end
               xs_in = {xs_ff[2*MdW-2:0], 1'b0};
               ys_in = {1'b0, ys_ff[MdW-1:1]};
            end
         end
         MD_DIV: begin
            rem_in = ge ? (r2[MdW-1:0] - z_ff) : r2[MdW-1:0];
            q_in   = {q_ff[MdW-2:0], ge};
            ys_in  = {ys_ff[MdW-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntW'(MdW - 1)) begin
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      acc_ff <= acc_in;
      xs_ff  <= xs_in;
      ys_ff  <= ys_in;
      z_ff   <= z_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign res.done = done_ff;
   assign res.q    = q_ff;

endmodule

@@ rtl/smpg_checker.sv @@
// ----------------------------------------------------------------------------
// smpg_checker: port-level checks of the S-curve profile generator
// Watches the result channel for held beats and consistent motion status.
// ----------------------------------------------------------------------------
module smpg_checker
   import smpg_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RspDataW-1:0] rsp_tdata
);

   logic [2:0] ph;
   assign ph = rsp_tdata[98:96];

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // An idle axis reports no motion at all.
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ph == PH_IDLE |->
         rsp_tdata[31:0] == '0 && rsp_tdata[63:32] == '0 && rsp_tdata[95:64] == '0)
      else $error("idle result with motion");

   // A finished move is at rest.
   a_done_rest: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ph == PH_DONE |-> rsp_tdata[63:32] == '0 && rsp_tdata[95:64] == '0)
      else $error("done result not at rest");

   // A refused start leaves the axis idle or done.
   a_refused: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[99] |-> ph == PH_IDLE || ph == PH_DONE)
      else $error("refused command left motion phase");

endmodule

bind scurve_motion_profile_generator smpg_checker u_smpg_checker (.*);

@@ sim/scurve_motion_profile_generator_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scurve_motion_profile_generator_checker: result predictor and scoreboard
// Watches the command, result and register channels of the profile
// generator, keeps its own copy of the motion state and the caps, predicts
// one result beat for every command beat and compares the beats in order.
// ----------------------------------------------------------------------------
module scurve_motion_profile_generator_checker
   import smpg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [31:0]         req_tdata,
   input  logic [2:0]          req_tuser,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [RspDataW-1:0] rsp_tdata,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data,
   output int                  fail_count,
   output int                  pending_count
);

   localparam bit [63:0] Cap48 = (64'd1 << 48) - 64'd1;

   // Listed from the top bit down, so position lands in the lowest bits.
   typedef struct packed {
      logic        accepted;
      logic [2:0]  phase;
      logic [31:0] acceleration;
      logic [31:0] velocity;
      logic [31:0] position;
   } motion_beat_type;

   motion_beat_type expected_beats[$];

   // Caps and tick period.
   bit [63:0] vel_cap, acc_cap, jerk_cap, period;

   // Motion state.
   phase_type phase_now;
   bit [63:0] path_len;
   longint    dist_left;
   bit [63:0] speed;
   longint    accel;
   bit        braking;

   function automatic bit [63:0] mul_div(bit [63:0] x, bit [63:0] y, bit [63:0] z);
      bit [127:0] q;
      if (z == 0) return Cap48;
      q = ({64'd0, x} * {64'd0, y}) / {64'd0, z};
      return (q > {64'd0, Cap48}) ? Cap48 : q[63:0];
   endfunction

   function automatic bit [63:0] add_sat(bit [63:0] a, bit [63:0] b);
      bit [63:0] s;
      s = a + b;
      return (s > Cap48) ? Cap48 : s;
   endfunction

   // Conservative distance needed to come to rest from the present state.
   function automatic bit [63:0] braking_distance();
      bit [63:0] ve, ramp, d, a;
      ve = speed;
      ramp = 0;
      if (speed == 0) return 0;
      if (jerk_cap > 0 && accel > 0) begin
         a = 64'(accel);
         ve = add_sat(ve, mul_div(a * a, 64'd128, jerk_cap));
         ramp = mul_div(ve, a, jerk_cap);
      end
      d = add_sat(mul_div(ve, ve, acc_cap << 9), mul_div(ve, period, 64'd1 << 33));
      d = add_sat(d, ramp);
      if (jerk_cap > 0) d = add_sat(d, mul_div(ve, acc_cap, 64'd2 * jerk_cap));
      return d;
   endfunction

   function automatic void clear_motion();
      phase_now = PH_IDLE;
      path_len  = 0;
      dist_left = 0;
      speed     = 0;
      accel     = 0;
      braking   = 0;
   endfunction

   task automatic advance_tick();
      longint    target, nv, adec, sw, ades, step, da, a;
      bit [63:0] mag, mag_a;
      if (period == 0 || phase_now == PH_IDLE || phase_now == PH_DONE) return;
      a = accel;
      if (phase_now == PH_PAUSE || phase_now == PH_ABORT) begin
         target = 0;
      end else begin
         // A move that stopped short of the end creeps on again.
         if (braking && speed <= VelEps && dist_left > longint'(SettleDist)) braking = 0;
         if (64'(dist_left) <= braking_distance()) braking = 1;
         target = braking ? 0 : longint'(vel_cap);
      end
      if (jerk_cap > 0) begin
         mag_a = (a < 0) ? 64'(-a) : 64'(a);
         adec = longint'(mul_div(mag_a * mag_a, 64'd128, jerk_cap));
         da = longint'((jerk_cap * period) >> 32);
         if (a < 0) adec = -adec;
         sw = (target - longint'(speed)) - adec;
         ades = 0;
         if (sw > 0) ades = longint'(acc_cap);
         else if (sw < 0) ades = -longint'(acc_cap);
         step = ades - a;
         if (step > da) step = da;
         if (step < -da) step = -da;
         a += step;
      end else begin
         if (longint'(speed) < target) a = longint'(acc_cap);
         else if (longint'(speed) > target) a = -longint'(acc_cap);
         else a = 0;
      end
      accel = a;
      mag_a = (a < 0) ? 64'(-a) : 64'(a);
      mag = (mag_a * period) >> 24;
      nv = longint'(speed) + ((a < 0) ? -longint'(mag) : longint'(mag));
      // The trapezoid lands exactly on the target speed.
      if (jerk_cap == 0) begin
         if (a > 0 && nv > target) nv = target;
         if (a < 0 && nv < target) nv = target;
      end
      if (nv < 0) nv = 0;
      if (nv > longint'(vel_cap)) nv = longint'(vel_cap);
      speed = 64'(nv);
      dist_left -= longint'((speed * period) >> 32);
      if (phase_now == PH_ABORT) begin
         if (speed <= VelEps) begin
            speed = 0;
            accel = 0;
         end
         if (dist_left < 0) dist_left = 0;
         return;
      end
      if (dist_left <= longint'(PosEps) ||
          (dist_left <= longint'(SettleDist) && speed <= SettleVel)) begin
         dist_left = 0;
         speed     = 0;
         accel     = 0;
         phase_now = PH_DONE;
      end
   endtask

   function automatic bit begin_move(bit [31:0] len);
      clear_motion();
      if (vel_cap == 0 || acc_cap == 0) return 0;
      if (len[31]) begin
         phase_now = PH_DONE;
         return 0;
      end
      path_len = 64'(len);
      if (len <= PosEps) begin
         phase_now = PH_DONE;
         return 1;
      end
      dist_left = longint'(len);
      phase_now = PH_RUN;
      return 1;
   endfunction

   task automatic predict_command(logic [2:0] act, logic [31:0] len);
      motion_beat_type b;
      bit     ok;
      longint pos;
      ok = 1;
      case (act)
         ACT_TICK:   advance_tick();
         ACT_START:  ok = begin_move(len);
         ACT_PAUSE:  if (phase_now == PH_RUN) phase_now = PH_PAUSE;
         ACT_RESUME: begin
            if (phase_now == PH_PAUSE) begin
               phase_now = PH_RUN;
               braking   = 0;
            end
         end
         ACT_ABORT:  if (phase_now == PH_RUN || phase_now == PH_PAUSE) phase_now = PH_ABORT;
         ACT_CLEAR:  clear_motion();
         default: ;
      endcase
      pos = longint'(path_len) - dist_left;
      if (pos < 0) pos = 0;
      b.position     = pos[31:0];
      b.velocity     = speed[31:0];
      b.acceleration = accel[31:0];
      b.phase        = phase_now;
      b.accepted     = ok;
      expected_beats.push_back(b);
   endtask

   task automatic compare_beat(motion_beat_type got);
      motion_beat_type want;
      if (expected_beats.size() == 0) begin
         $error("result beat with no command outstanding: %h", got);
         fail_count++;
         return;
      end
      want = expected_beats.pop_front();
      if (got.position !== want.position) begin
         $error("position: expected %h, actual %h", want.position, got.position);
         fail_count++;
      end
      if (got.velocity !== want.velocity) begin
         $error("velocity: expected %h, actual %h", want.velocity, got.velocity);
         fail_count++;
      end
      if (got.acceleration !== want.acceleration) begin
         $error("acceleration: expected %h, actual %h", want.acceleration,
                got.acceleration);
         fail_count++;
      end
      if (got.phase !== want.phase) begin
         $error("phase: expected %0d, actual %0d", want.phase, got.phase);
         fail_count++;
      end
      if (got.accepted !== want.accepted) begin
         $error("accepted: expected %0d, actual %0d", want.accepted, got.accepted);
         fail_count++;
      end
   endtask

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         vel_cap  = 0;
         acc_cap  = 0;
         jerk_cap = 0;
         period   = 64'd4294967;
         clear_motion();
         expected_beats.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) compare_beat(motion_beat_type'(rsp_tdata[99:0]));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_VEL:  vel_cap  = 64'(csr_data);
               CSR_MAX_ACC:  acc_cap  = 64'(csr_data[30:0]);
               CSR_MAX_JERK: jerk_cap = 64'(csr_data[30:0]);
               CSR_TICK:     period   = 64'(csr_data);
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_command(req_tuser, req_tdata);
      end
      pending_count = expected_beats.size();
   end

endmodule

@@ sim/scurve_motion_profile_generator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scurve_motion_profile_generator_tb: top of the profile generator bench
// Drives commands and register writes, runs a directed opening and then random
// move sequences under several cap settings with random command gaps and result
// stalls; the checker beside the block judges every beat.
// ----------------------------------------------------------------------------
module scurve_motion_profile_generator_tb;
   import smpg_pkg::*;

   // Ten milliseconds in Q0.32 seconds.
   localparam logic [31:0] TenMs      = 32'd42949673;
   localparam int          CycleLimit = 4000000;

   logic                clock = 0;
   logic                reset = 1;
   logic                req_tvalid = 0;
   logic                req_tready;
   logic [31:0]         req_tdata = 0;
   logic [2:0]          req_tuser = 0;
   logic                rsp_tvalid;
   logic                rsp_tready = 0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                csr_valid = 0;
   logic                csr_ready;
   logic [1:0]          csr_index = 0;
   logic [31:0]         csr_data = 0;

   int fail_count;
   int pending_count;
   int cycle_count = 0;
   // Set by the stimulus to make the receiver hold off for a long stretch.
   bit long_stall = 0;

   scurve_motion_profile_generator dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   scurve_motion_profile_generator_checker checker_i (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .fail_count, .pending_count
   );

   always #1 clock = ~clock;

   // A hung block ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver: a random hold-off before each beat, and once a long one while
   // the sender keeps offering commands so the block backs up into its input.
   initial begin : receiver
      int w;
      @(negedge reset);
      forever begin
         @(posedge clock);
         w = long_stall ? 2000 : $urandom_range(0, 6);
         if (long_stall) long_stall = 0;
         if (w > 0) begin
            rsp_tready <= 0;
            repeat (w - 1) @(posedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // One command beat; valid stays high into the next beat when no gap is drawn.
   task automatic send_command(logic [2:0] act, logic [31:0] len);
      int gap;
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= act;
      req_tdata  <= len;
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   // Stop offering commands until every result has come back.
   task automatic drain();
      req_tvalid <= 0;
      do @(posedge clock); while (pending_count != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic set_caps(logic [31:0] v, logic [31:0] a, logic [31:0] j, logic [31:0] t);
      drain();
      write_csr(CSR_MAX_VEL, v);
      write_csr(CSR_MAX_ACC, a);
      write_csr(CSR_MAX_JERK, j);
      write_csr(CSR_TICK, t);
   endtask

   // Mostly well-formed moves: a start followed by a run of ticks, with pause,
   // resume, abort, clear, unused codes and raw starts sprinkled in as noise.
   task automatic random_moves(int n);
      int sent, run, k;
      logic [2:0] act;
      sent = 0;
      while (sent < n) begin
         if ($urandom_range(0, 14) == 0) send_command(ACT_START, $urandom());
         else send_command(ACT_START, $urandom_range(1 << 10, 24 << 16));
         sent++;
         run = $urandom_range(5, 60);
         for (k = 0; k < run && sent < n; k++) begin
            if ($urandom_range(0, 11) == 0) act = 3'($urandom_range(2, 7));
            else act = ACT_TICK;
            // A paused axis is usually resumed a little later.
            send_command(act, $urandom());
            sent++;
            if (act == ACT_PAUSE && $urandom_range(0, 2) != 0 && sent < n) begin
               send_command(ACT_TICK, $urandom());
               send_command(ACT_RESUME, $urandom());
               sent += 2;
            end
         end
      end
   endtask

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed opening. Caps still zero after reset, so start fails.
      send_command(ACT_START, 32'd10 << 16);
      send_command(ACT_TICK, 32'hFFFF_FFFF);
      set_caps(32'd20 << 16, 32'd100 << 8, 32'd1000 << 8, TenMs);
      send_command(ACT_START, 32'h8000_0000);      // negative length
      send_command(ACT_START, 32'd0);
      send_command(ACT_START, 32'd1);              // one LSB: done at once
      send_command(ACT_TICK, 32'd0);               // tick while done
      send_command(ACT_START, 32'd2);
      send_command(ACT_TICK, 32'd0);
      send_command(ACT_START, 32'd3 << 16);
      send_command(ACT_TICK, 32'd0);
      send_command(ACT_PAUSE, 32'd0);
      send_command(ACT_TICK, 32'd0);
      send_command(ACT_RESUME, 32'd0);
      send_command(ACT_TICK, 32'd0);
      send_command(ACT_ABORT, 32'd0);
      send_command(ACT_TICK, 32'd0);
      send_command(3'd6, 32'd0);
      send_command(3'd7, 32'h7FFF_FFFF);
      send_command(ACT_CLEAR, 32'd0);
      send_command(ACT_START, 32'h7FFF_FFFF);
      send_command(ACT_TICK, 32'd0);
      // A zero acceleration cap in mid-move forces braking.
      set_caps(32'd20 << 16, 32'd0, 32'd1000 << 8, TenMs);
      send_command(ACT_TICK, 32'd0);
      // A zero tick period freezes motion.
      set_caps(32'd20 << 16, 32'd100 << 8, 32'd0, 32'd0);
      send_command(ACT_TICK, 32'd0);

      // Plain trapezoid.
      set_caps(32'd20 << 16, 32'd100 << 8, 32'd0, TenMs);
      random_moves(180);

      // Jerk-limited, with one long receiver stall while commands keep coming.
      set_caps(32'd20 << 16, 32'd200 << 8, 32'd2000 << 8, TenMs);
      long_stall = 1;
      random_moves(180);

      // Every cap at its top.
      set_caps(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      random_moves(90);

      // Smallest nonzero caps.
      set_caps(32'd1, 32'd1, 32'd1, 32'd1);
      random_moves(40);

      // Random moderate settings, trapezoid now and then.
      repeat (3) begin
         set_caps($urandom_range(1 << 16, 50 << 16), $urandom_range(1 << 8, 500 << 8),
                  ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1 << 8, 5000 << 8),
                  $urandom_range(1 << 24, 1 << 27));
         random_moves(80);
      end

      drain();
      repeat (1000) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/smpg_pkg.sv
rtl/smpg_muldiv.sv
rtl/scurve_motion_profile_generator.sv
rtl/smpg_checker.sv
sim/scurve_motion_profile_generator_checker.sv
sim/scurve_motion_profile_generator_tb.sv
